// ===== hdl/lpht_pkg.sv =====
// Package for the linear probe hash table.
// Holds table geometry, command and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package lpht_pkg;

    // Table size is a power of two, so the home slot is the low key bits.
    localparam int TABLE_SIZE  = 64;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int KEY_W       = 32;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_W     = 7;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = KEY_W + 2 * HANDLE_BITS;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 2;

    localparam logic [COUNT_W-1:0] LOAD_LIMIT_RESET = 7'd48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_NULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OUT_HIT,
        OUT_MISS,
        OUT_NULL
    } outcome_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     rd;
        logic     adv;
        logic     tomb_cap;
        logic     finish;
        outcome_t outcome;
    } ctrl_cmd_t;

    typedef struct packed {
        logic null_insert;
        logic is_find;
        logic mark_empty;
        logic mark_used;
        logic key_match;
        logic cbk_match;
        logic last_step;
        logic tomb_valid;
        logic out_free;
    } dp_stat_t;

endpackage : lpht_pkg

`default_nettype wire

// ===== hdl/lpht_ifs.sv =====
// Request and response channel interfaces for the linear probe hash table.
// Depends on lpht_pkg for field widths.
`default_nettype none

interface lpht_req_if;
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] packet_handle;
    logic [HANDLE_BITS-1:0] callback_handle;

    modport source (
        output valid, command, key, packet_handle, callback_handle,
        input  ready
    );

    modport sink (
        input  valid, command, key, packet_handle, callback_handle,
        output ready
    );
endinterface : lpht_req_if

interface lpht_rsp_if;
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [HANDLE_BITS-1:0] found_packet;
    logic [HANDLE_BITS-1:0] found_callback;
    logic [COUNT_W-1:0]     entry_count;

    modport source (
        output valid, status, found_packet, found_callback, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, found_packet, found_callback, entry_count,
        output ready
    );
endinterface : lpht_rsp_if

`default_nettype wire

// ===== hdl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table: controller, datapath, config regs.
// Depends on lpht_pkg, lpht_ifs, lpht_cfg_regs, lpht_ctrl, lpht_datapath.
//
//   channel | kind       | fields
//   --------+------------+----------------------------------------------------
//   req     | valid/rdy  | command, key, packet_handle, callback_handle
//   rsp     | valid/rdy  | status, found_packet, found_callback, entry_count
//   apb     | APB        | load_limit, read at address 0, written at any address
//
// A request is accepted in S_IDLE; each slot visited then passes S_READ, where
// the slot memory read is registered, and S_CHECK, where the slot is checked.
// A probe ends on a hit or (but for find-callback) an empty slot, at most 64 slots;
// find-callback walks slots in order. A null packet insert skips the slot read.
// Reset clears all slot marks and the entry count at once; no sweep is needed.
// A finished response waits in the output register; the controller holds
// its final slot until that register is free.
`default_nettype none

module linear_probe_hash_table (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lpht_req_if.sink                             req,
    lpht_rsp_if.source                           rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lpht_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lpht_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lpht_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import lpht_pkg::*;

    logic [COUNT_W-1:0] load_limit;
    ctrl_cmd_t          ctrl_cmd;
    dp_stat_t           dp_stat;
    logic               req_ready;

    lpht_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .load_limit (load_limit)
    );

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (dp_stat),
        .req_ready (req_ready),
        .cmd       (ctrl_cmd)
    );

    lpht_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_command         (req.command),
        .req_key             (req.key),
        .req_packet_handle   (req.packet_handle),
        .req_callback_handle (req.callback_handle),
        .load_limit          (load_limit),
        .cmd                 (ctrl_cmd),
        .stat                (dp_stat),
        .rsp_ready           (rsp.ready),
        .rsp_valid           (rsp.valid),
        .rsp_status          (rsp.status),
        .rsp_found_packet    (rsp.found_packet),
        .rsp_found_callback  (rsp.found_callback),
        .rsp_entry_count     (rsp.entry_count)
    );

    assign req.ready = req_ready;

endmodule : linear_probe_hash_table

`default_nettype wire

// ===== hdl/lpht_cfg_regs.sv =====
// APB configuration register block: holds load_limit.
// Depends on lpht_pkg.
`default_nettype none

module lpht_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lpht_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lpht_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lpht_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [lpht_pkg::COUNT_W-1:0]    load_limit
);
    import lpht_pkg::*;

    logic [COUNT_W-1:0] load_limit_reg;
    logic [COUNT_W-1:0] load_limit_next;
    logic               wr_en;
    logic               rd_word;

    // Only one register: reads see it at byte address zero, writes ignore paddr.
    assign rd_word = (paddr == '0);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        load_limit_next = load_limit_reg;
        if (wr_en)
        begin
            load_limit_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= LOAD_LIMIT_RESET;
        end
        else
        begin
            load_limit_reg <= load_limit_next;
        end
    end

    assign pready     = 1'b1;
    assign prdata     = rd_word ? {{(APB_DATA_W-COUNT_W){1'b0}}, load_limit_reg} : '0;
    assign load_limit = load_limit_reg;

endmodule : lpht_cfg_regs

`default_nettype wire

// ===== hdl/lpht_ctrl.sv =====
// Controller state machine: sequences slot reads and checks for each request.
// Depends on lpht_pkg; drives lpht_datapath through ctrl_cmd_t.
`default_nettype none

module lpht_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire lpht_pkg::dp_stat_t   stat,
    output logic                      req_ready,
    output lpht_pkg::ctrl_cmd_t       cmd
);
    import lpht_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   slot_hit;
    logic   probe_end;

    // Hit on this slot, or probe over without a hit.
    assign slot_hit  = stat.mark_used && (stat.is_find ? stat.cbk_match : stat.key_match);
    assign probe_end = slot_hit || stat.last_step || (!stat.is_find && stat.mark_empty);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (!stat.null_insert)
                begin
                    state_next = S_CHECK;
                end
                else if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (!probe_end)
                begin
                    state_next = S_READ;
                end
                else if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.outcome = OUT_MISS;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            S_READ:
            begin
                if (!stat.null_insert)
                begin
                    cmd.rd = 1'b1;
                end
                else
                begin
                    cmd.finish  = stat.out_free;
                    cmd.outcome = OUT_NULL;
                end
            end
            S_CHECK:
            begin
                if (!probe_end)
                begin
                    cmd.adv      = 1'b1;
                    cmd.tomb_cap = !stat.is_find && !stat.mark_used && !stat.tomb_valid;
                end
                else
                begin
                    cmd.finish  = stat.out_free;
                    cmd.outcome = slot_hit ? OUT_HIT : OUT_MISS;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : lpht_ctrl

`default_nettype wire

// ===== hdl/lpht_datapath.sv =====
// Datapath: request registers, slot marks, slot memory, entry count and
// response register. Depends on lpht_pkg; commanded by lpht_ctrl.
`default_nettype none

module lpht_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [lpht_pkg::CMD_W-1:0]        req_command,
    input  wire logic [lpht_pkg::KEY_W-1:0]        req_key,
    input  wire logic [lpht_pkg::HANDLE_BITS-1:0]  req_packet_handle,
    input  wire logic [lpht_pkg::HANDLE_BITS-1:0]  req_callback_handle,
    input  wire logic [lpht_pkg::COUNT_W-1:0]      load_limit,
    input  wire lpht_pkg::ctrl_cmd_t               cmd,
    output lpht_pkg::dp_stat_t                     stat,
    input  wire logic                              rsp_ready,
    output logic                                   rsp_valid,
    output logic      [lpht_pkg::STATUS_W-1:0]     rsp_status,
    output logic      [lpht_pkg::HANDLE_BITS-1:0]  rsp_found_packet,
    output logic      [lpht_pkg::HANDLE_BITS-1:0]  rsp_found_callback,
    output logic      [lpht_pkg::COUNT_W-1:0]      rsp_entry_count
);
    import lpht_pkg::*;

    localparam int CBK_LSB = 0;
    localparam int PKT_LSB = HANDLE_BITS;
    localparam int KEY_LSB = 2 * HANDLE_BITS;

    cmd_t                   req_cmd_reg;
    logic [KEY_W-1:0]       req_key_reg;
    logic [HANDLE_BITS-1:0] req_pkt_reg;
    logic [HANDLE_BITS-1:0] req_cbk_reg;

    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       step_reg;
    logic [IDX_W-1:0]       tomb_idx_reg;
    logic                   tomb_valid_reg;

    logic [TABLE_SIZE-1:0]  used_reg;
    logic [TABLE_SIZE-1:0]  used_next;
    logic [TABLE_SIZE-1:0]  tomb_reg;
    logic [TABLE_SIZE-1:0]  tomb_next;
    logic                   mq_used_reg;
    logic                   mq_tomb_reg;

    logic [SLOT_W-1:0]      mem [TABLE_SIZE];
    logic [SLOT_W-1:0]      mem_q_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [SLOT_W-1:0]      mem_wdata;

    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic                   at_limit;
    logic                   free_valid;
    logic [IDX_W-1:0]       free_idx;

    logic                   out_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [HANDLE_BITS-1:0] fpkt_reg;
    logic [HANDLE_BITS-1:0] fpkt_next;
    logic [HANDLE_BITS-1:0] fcbk_reg;
    logic [HANDLE_BITS-1:0] fcbk_next;
    logic [COUNT_W-1:0]     entry_count_reg;

    logic                   out_free;

    // Request capture and probe cursor.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_cmd_reg <= cmd_t'(req_command);
            req_key_reg <= req_key;
            req_pkt_reg <= req_packet_handle;
            req_cbk_reg <= req_callback_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            step_reg       <= '0;
            tomb_idx_reg   <= '0;
            tomb_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            idx_reg        <= (cmd_t'(req_command) == CMD_FIND) ? '0 : req_key[IDX_W-1:0];
            step_reg       <= '0;
            tomb_valid_reg <= 1'b0;
        end
        else if (cmd.adv)
        begin
            idx_reg  <= idx_reg + 1'b1;
            step_reg <= step_reg + 1'b1;
            if (cmd.tomb_cap)
            begin
                tomb_idx_reg   <= idx_reg;
                tomb_valid_reg <= 1'b1;
            end
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            mem_q_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            tomb_reg    <= '0;
            mq_used_reg <= 1'b0;
            mq_tomb_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            tomb_reg  <= tomb_next;
            count_reg <= count_next;
            if (cmd.rd)
            begin
                mq_used_reg <= used_reg[idx_reg];
                mq_tomb_reg <= tomb_reg[idx_reg];
            end
        end
    end

    assign at_limit   = ({1'b0, count_reg} + 1'b1) >= {1'b0, load_limit};
    assign free_valid = tomb_valid_reg || !mq_used_reg;
    assign free_idx   = tomb_valid_reg ? tomb_idx_reg : idx_reg;
    assign mem_wdata  = {req_key_reg, req_pkt_reg, req_cbk_reg};

    always_comb
    begin
        used_next   = used_reg;
        tomb_next   = tomb_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        status_next = ST_MISS;
        fpkt_next   = '0;
        fcbk_next   = '0;
        if (cmd.finish)
        begin
            unique case (req_cmd_reg)
                CMD_INSERT:
                begin
                    priority if (cmd.outcome == OUT_NULL)
                    begin
                        status_next = ST_NULL;
                    end
                    else if (cmd.outcome == OUT_HIT)
                    begin
                        mem_we      = 1'b1;
                        status_next = ST_OK;
                    end
                    else if (at_limit || !free_valid)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we              = 1'b1;
                        mem_waddr           = free_idx;
                        used_next[free_idx] = 1'b1;
                        tomb_next[free_idx] = 1'b0;
                        count_next          = count_reg + 1'b1;
                        status_next         = ST_OK;
                    end
                end
                CMD_LOOKUP:
                begin
                    if (cmd.outcome == OUT_HIT)
                    begin
                        fpkt_next   = mem_q_reg[PKT_LSB +: HANDLE_BITS];
                        fcbk_next   = mem_q_reg[CBK_LSB +: HANDLE_BITS];
                        status_next = ST_OK;
                    end
                end
                CMD_REMOVE:
                begin
                    if (cmd.outcome == OUT_HIT)
                    begin
                        used_next[idx_reg] = 1'b0;
                        tomb_next[idx_reg] = 1'b1;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        status_next = ST_OK;
                    end
                end
                CMD_FIND:
                begin
                    if (cmd.outcome == OUT_HIT)
                    begin
                        status_next = ST_OK;
                    end
                end
                default:
                begin
                    status_next = ST_MISS;
                end
            endcase
        end
    end

    // Response register.
    assign out_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg      <= status_next;
            fpkt_reg        <= fpkt_next;
            fcbk_reg        <= fcbk_next;
            entry_count_reg <= count_next;
        end
    end

    assign stat.null_insert = (req_cmd_reg == CMD_INSERT) && (req_pkt_reg == '0);
    assign stat.is_find     = (req_cmd_reg == CMD_FIND);
    assign stat.mark_empty  = !mq_used_reg && !mq_tomb_reg;
    assign stat.mark_used   = mq_used_reg;
    assign stat.key_match   = (mem_q_reg[KEY_LSB +: KEY_W] == req_key_reg);
    assign stat.cbk_match   = (mem_q_reg[CBK_LSB +: HANDLE_BITS] == req_cbk_reg);
    assign stat.last_step   = (step_reg == IDX_W'(TABLE_SIZE - 1));
    assign stat.tomb_valid  = tomb_valid_reg;
    assign stat.out_free    = out_free;

    assign rsp_valid          = out_valid_reg;
    assign rsp_status         = status_reg;
    assign rsp_found_packet   = fpkt_reg;
    assign rsp_found_callback = fcbk_reg;
    assign rsp_entry_count    = entry_count_reg;

endmodule : lpht_datapath

`default_nettype wire

// ===== bench/tb_linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// Testbench for linear_probe_hash_table: directed and random request traffic,
// a shadow hash table that predicts every response, and load limit sweeps.
// Depends on lpht_pkg, the lpht_req_if/lpht_rsp_if interfaces and the RTL top.
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    typedef enum logic [1:0] {
        SLOT_EMPTY,
        SLOT_USED,
        SLOT_TOMB
    } slot_mark_e;

    typedef struct packed {
        cmd_t                   command;
        logic [KEY_W-1:0]       key;
        logic [HANDLE_BITS-1:0] packet_handle;
        logic [HANDLE_BITS-1:0] callback_handle;
    } hash_req_t;

    typedef struct packed {
        status_t                status;
        logic [HANDLE_BITS-1:0] found_packet;
        logic [HANDLE_BITS-1:0] found_callback;
        logic [COUNT_W-1:0]     entry_count;
    } hash_rsp_t;

    localparam logic [APB_ADDR_W-1:0] ADDR_LOAD_LIMIT = '0;
    localparam int DRAIN_CYCLES = 4 * TABLE_SIZE;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lpht_req_if req ();
    lpht_rsp_if rsp ();

    linear_probe_hash_table u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    slot_mark_e             tbl_mark [TABLE_SIZE];
    logic [KEY_W-1:0]       tbl_key  [TABLE_SIZE];
    logic [HANDLE_BITS-1:0] tbl_pkt  [TABLE_SIZE];
    logic [HANDLE_BITS-1:0] tbl_cbk  [TABLE_SIZE];
    int unsigned            tbl_count;
    logic [COUNT_W-1:0]     load_limit_cfg;

    hash_req_t              pending_reqs [$];
    hash_rsp_t              expected_rsps [$];
    logic [KEY_W-1:0]       key_pool [$];
    logic [HANDLE_BITS-1:0] cbk_pool [16];

    int   send_idle_pct;
    int   recv_idle_pct;
    int   err_count;
    logic req_fire;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic bit probe_slot(input logic [KEY_W-1:0] k, output int hit_idx,
                                      output int free_idx);
        int idx;
        int tomb;
        int n;
        idx      = int'(k[IDX_W-1:0]);
        tomb     = TABLE_SIZE;
        hit_idx  = 0;
        free_idx = TABLE_SIZE;
        for (n = 0; n < TABLE_SIZE; n++)
        begin
            if (tbl_mark[idx] == SLOT_EMPTY)
            begin
                free_idx = (tomb != TABLE_SIZE) ? tomb : idx;
                return 1'b0;
            end
            if (tbl_mark[idx] == SLOT_USED)
            begin
                if (tbl_key[idx] == k)
                begin
                    hit_idx = idx;
                    return 1'b1;
                end
            end
            else if (tomb == TABLE_SIZE)
                tomb = idx;
            idx = (idx + 1) % TABLE_SIZE;
        end
        free_idx = tomb;
        return 1'b0;
    endfunction

    function automatic hash_rsp_t predict_response(input hash_req_t r);
        hash_rsp_t p;
        int        hit_idx;
        int        free_idx;
        int        i;
        bit        hit;
        p.status         = ST_MISS;
        p.found_packet   = '0;
        p.found_callback = '0;
        case (r.command)
            CMD_INSERT:
            begin
                if (r.packet_handle == '0)
                    p.status = ST_NULL;
                else
                begin
                    hit = probe_slot(r.key, hit_idx, free_idx);
                    if (hit)
                    begin
                        tbl_pkt[hit_idx] = r.packet_handle;
                        tbl_cbk[hit_idx] = r.callback_handle;
                        p.status         = ST_OK;
                    end
                    else if (tbl_count + 1 >= load_limit_cfg || free_idx >= TABLE_SIZE)
                        p.status = ST_FULL;
                    else
                    begin
                        tbl_mark[free_idx] = SLOT_USED;
                        tbl_key[free_idx]  = r.key;
                        tbl_pkt[free_idx]  = r.packet_handle;
                        tbl_cbk[free_idx]  = r.callback_handle;
                        tbl_count++;
                        p.status = ST_OK;
                    end
                end
            end
            CMD_LOOKUP:
            begin
                if (probe_slot(r.key, hit_idx, free_idx))
                begin
                    p.found_packet   = tbl_pkt[hit_idx];
                    p.found_callback = tbl_cbk[hit_idx];
                    p.status         = ST_OK;
                end
            end
            CMD_REMOVE:
            begin
                if (probe_slot(r.key, hit_idx, free_idx))
                begin
                    tbl_mark[hit_idx] = SLOT_TOMB;
                    if (tbl_count > 0)
                        tbl_count--;
                    p.status = ST_OK;
                end
            end
            default:
            begin
                for (i = 0; i < TABLE_SIZE; i++)
                    if (tbl_mark[i] == SLOT_USED && tbl_cbk[i] == r.callback_handle)
                        p.status = ST_OK;
            end
        endcase
        p.entry_count = COUNT_W'(tbl_count);
        return p;
    endfunction

    // Check responses first, then predict the request taken at the same edge.
    always @(posedge clk)
    begin
        hash_rsp_t want;
        hash_req_t taken;
        req_fire <= rst_n && req.valid && req.ready;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch($sformatf("response with nothing pending, status %0d",
                                          rsp.status));
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp.status, want.status));
                if (rsp.found_packet !== want.found_packet)
                    report_mismatch($sformatf("found_packet got %h want %h",
                                              rsp.found_packet, want.found_packet));
                if (rsp.found_callback !== want.found_callback)
                    report_mismatch($sformatf("found_callback got %h want %h",
                                              rsp.found_callback, want.found_callback));
                if (rsp.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              rsp.entry_count, want.entry_count));
            end
        end
        if (rst_n && req.valid && req.ready)
        begin
            taken.command         = cmd_t'(req.command);
            taken.key             = req.key;
            taken.packet_handle   = req.packet_handle;
            taken.callback_handle = req.callback_handle;
            expected_rsps.push_back(predict_response(taken));
        end
    end

    // Hold a request until accepted, then advance or idle.
    always @(negedge clk)
    begin
        hash_req_t nxt;
        if (rst_n && (!req.valid || req_fire))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                req.valid           <= 1'b1;
                req.command         <= nxt.command;
                req.key             <= nxt.key;
                req.packet_handle   <= nxt.packet_handle;
                req.callback_handle <= nxt.callback_handle;
            end
            else
                req.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic push_req(input cmd_t c, input logic [KEY_W-1:0] k,
                            input logic [HANDLE_BITS-1:0] pkt,
                            input logic [HANDLE_BITS-1:0] cbk);
        hash_req_t r;
        r.command         = c;
        r.key             = k;
        r.packet_handle   = pkt;
        r.callback_handle = cbk;
        pending_reqs.push_back(r);
    endtask

    // Half the keys crowd around the wrap point of the table.
    task automatic make_key_pool(input int n);
        logic [KEY_W-1:0] k;
        int               i;
        key_pool.delete();
        for (i = 0; i < n; i++)
        begin
            k = $urandom();
            if ($urandom_range(1) == 1)
                k[IDX_W-1:0] = IDX_W'(TABLE_SIZE - 4 + $urandom_range(7));
            key_pool.push_back(k);
        end
    endtask

    task automatic queue_random(input int n, input int ins_pct, input int look_pct,
                                input int rem_pct);
        hash_req_t r;
        int        i;
        int        pick;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < ins_pct)
                r.command = CMD_INSERT;
            else if (pick < ins_pct + look_pct)
                r.command = CMD_LOOKUP;
            else if (pick < ins_pct + look_pct + rem_pct)
                r.command = CMD_REMOVE;
            else
                r.command = CMD_FIND;
            if (key_pool.size() != 0 && $urandom_range(99) < 85)
                r.key = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                r.key = $urandom();
            pick = $urandom_range(99);
            if (pick < 5)
                r.packet_handle = '0;
            else if (pick < 8)
                r.packet_handle = '1;
            else
                r.packet_handle = HANDLE_BITS'($urandom_range(65535, 1));
            if ($urandom_range(99) < 70)
                r.callback_handle = cbk_pool[$urandom_range(15)];
            else
                r.callback_handle = HANDLE_BITS'($urandom());
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write load_limit once the table is idle, then read it back.
    task automatic set_load_limit(input logic [COUNT_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LOAD_LIMIT;
        pwdata  <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        load_limit_cfg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(value))
            report_mismatch($sformatf("load_limit read back %h want %h", prdata, value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int i;
        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.command         = CMD_INSERT;
        req.key             = '0;
        req.packet_handle   = '0;
        req.callback_handle = '0;
        rsp.ready           = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        err_count           = 0;
        tbl_count           = 0;
        load_limit_cfg      = LOAD_LIMIT_RESET;
        send_idle_pct       = 17;
        recv_idle_pct       = 66;
        for (i = 0; i < TABLE_SIZE; i++)
            tbl_mark[i] = SLOT_EMPTY;
        cbk_pool[0] = '0;
        cbk_pool[1] = '1;
        cbk_pool[2] = 16'h5555;
        cbk_pool[3] = 16'hAAAA;
        for (i = 4; i < 16; i++)
            cbk_pool[i] = HANDLE_BITS'($urandom());

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, null insert, collisions on slot 0, tombstone reuse,
        // wrap from slot 63, replace of an existing key.
        push_req(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 16'h0000);
        push_req(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        push_req(CMD_FIND,   32'h0000_0000, 16'h0000, 16'h0000);
        push_req(CMD_INSERT, 32'h0000_0000, 16'h0000, 16'h1234);
        push_req(CMD_INSERT, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
        push_req(CMD_INSERT, 32'h0000_0040, 16'h0001, 16'h0000);
        push_req(CMD_INSERT, 32'hFFFF_FFC0, 16'h8000, 16'h1234);
        push_req(CMD_LOOKUP, 32'h0000_0040, 16'h0000, 16'h0000);
        push_req(CMD_INSERT, 32'h0000_0000, 16'h00AA, 16'h5555);
        push_req(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 16'h0000);
        push_req(CMD_REMOVE, 32'h0000_0040, 16'h0000, 16'h0000);
        push_req(CMD_LOOKUP, 32'hFFFF_FFC0, 16'h0000, 16'h0000);
        push_req(CMD_LOOKUP, 32'h0000_0040, 16'h0000, 16'h0000);
        push_req(CMD_INSERT, 32'h0000_0080, 16'h7FFF, 16'hAAAA);
        push_req(CMD_FIND,   32'h0000_0000, 16'h0000, 16'h5555);
        push_req(CMD_FIND,   32'h0000_0000, 16'h0000, 16'hFFFF);
        push_req(CMD_INSERT, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF);
        push_req(CMD_INSERT, 32'h0000_007F, 16'h1234, 16'h0000);
        push_req(CMD_LOOKUP, 32'h0000_007F, 16'h0000, 16'h0000);
        push_req(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        push_req(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        push_req(CMD_LOOKUP, 32'h0000_007F, 16'h0000, 16'h0000);
        push_req(CMD_INSERT, 32'h0000_0000, 16'h0000, 16'hFFFF);
        push_req(CMD_FIND,   32'h0000_0000, 16'hFFFF, 16'h0000);

        set_load_limit(7'd0);
        make_key_pool(24);
        queue_random(25, 50, 20, 15);
        set_load_limit(7'd2);
        queue_random(35, 45, 25, 20);
        set_load_limit(7'd127);
        make_key_pool(96);
        queue_random(220, 65, 15, 10);

        send_idle_pct = 66;
        recv_idle_pct = 17;
        // hold new requests until the table has answered everything
        wait_idle();
        queue_random(150, 35, 20, 35);
        set_load_limit(7'd64);
        make_key_pool(80);
        queue_random(150, 40, 25, 20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_load_limit(7'd1);
        queue_random(20, 50, 25, 10);
        set_load_limit(LOAD_LIMIT_RESET);
        make_key_pool(60);
        queue_random(150, 45, 25, 15);
        set_load_limit(7'd100);
        queue_random(100, 40, 30, 20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_rsps.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lpht_pkg.sv
hdl/lpht_ifs.sv
hdl/lpht_cfg_regs.sv
hdl/lpht_ctrl.sv
hdl/lpht_datapath.sv
hdl/linear_probe_hash_table.sv
bench/tb_linear_probe_hash_table.sv
